[sv/chip8_instruction_execute_defines.svh]
// Assertion macros shared by the execute unit
`ifndef CHIP8_INSTRUCTION_EXECUTE_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTE_DEFINES_SVH

// implication checked at every clock outside reset
`define C8_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define C8_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/chip8ie_pkg.sv]
// Types and constants of the CHIP-8 execute unit
`timescale 1ns / 1ps
package chip8ie_pkg;

  localparam logic [15:0] INS_CLS      = 16'h00E0;
  localparam logic [15:0] INS_RET      = 16'h00EE;
  localparam logic [7:0]  NN_ADD_I     = 8'h1E;
  localparam logic [3:0]  FLAG_REG     = 4'hF;
  localparam logic [11:0] PROG_START_RST = 12'd512;

  typedef enum logic [3:0] {
    OP_SYS     = 4'h0,
    OP_JP      = 4'h1,
    OP_CALL    = 4'h2,
    OP_SE_IMM  = 4'h3,
    OP_SNE_IMM = 4'h4,
    OP_SE_REG  = 4'h5,
    OP_LD_IMM  = 4'h6,
    OP_ADD_IMM = 4'h7,
    OP_ALU     = 4'h8,
    OP_SNE_REG = 4'h9,
    OP_LD_I    = 4'hA,
    OP_JP_V0   = 4'hB,
    OP_RND     = 4'hC,
    OP_DRW     = 4'hD,
    OP_SKP     = 4'hE,
    OP_MISC    = 4'hF
  } opclass_t;

  typedef enum logic [3:0] {
    ALU_MOV = 4'h0,
    ALU_OR  = 4'h1,
    ALU_AND = 4'h2,
    ALU_XOR = 4'h3,
    ALU_ADD = 4'h4,
    ALU_SUB = 4'h5,
    ALU_SHR = 4'h6,
    ALU_SBN = 4'h7,
    ALU_SHL = 4'hE
  } alu_op_t;

  typedef struct packed {
    logic [15:0] instruction;
    logic [7:0]  random_byte;
  } in_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [11:0] index_value;
    logic        write_enable;
    logic [3:0]  write_reg;
    logic [7:0]  write_value;
    logic        clear_screen;
    logic        not_handled;
    logic        stack_fault;
  } out_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [11:0] ret_addr;
    logic        idx_wr;
    logic [11:0] idx_val;
    logic        wr;
    logic [3:0]  wr_reg;
    logic [7:0]  res;
    logic        set_flag;
    logic        flag;
    logic        push;
    logic        pop;
    logic        clr;
    logic        unh;
    logic        fault;
  } exec_ctl_t;

endpackage

[sv/chip8ie_regfile.sv]
// Sixteen 8-bit data registers with X/Y/V0 reads and flag write port
`timescale 1ns / 1ps
module chip8ie_regfile import chip8ie_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       we,
  input  logic [3:0] waddr,
  input  logic [7:0] wdata,
  input  logic       flag_we,
  input  logic       flag,
  input  logic [3:0] raddr_x,
  input  logic [3:0] raddr_y,
  output logic [7:0] rdata_x,
  output logic [7:0] rdata_y,
  output logic [7:0] rdata_0
);

  logic [7:0] regs_r [16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) regs_r[i] <= '0;
    end else begin
      if (we && !(flag_we && waddr == FLAG_REG)) regs_r[waddr] <= wdata;
      // flag lands last
      if (flag_we) regs_r[FLAG_REG] <= {7'd0, flag};
    end
  end

  assign rdata_x = regs_r[raddr_x];
  assign rdata_y = regs_r[raddr_y];
  assign rdata_0 = regs_r[0];

endmodule

[sv/chip8ie_exec.sv]
// Instruction decode and execute datapath
`timescale 1ns / 1ps
module chip8ie_exec import chip8ie_pkg::*; (
  input  logic [15:0] instruction,
  input  logic [7:0]  random_byte,
  input  logic [11:0] pc,
  input  logic [11:0] index,
  input  logic [7:0]  vx,
  input  logic [7:0]  vy,
  input  logic [7:0]  v0,
  input  logic [11:0] stack_top,
  input  logic        stack_full,
  input  logic        stack_empty,
  output exec_ctl_t   ctl
);

  opclass_t    cls;
  alu_op_t     alu_op;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [11:0] pc2;
  logic [11:0] pc4;
  logic [8:0]  add_sum;

  assign cls     = opclass_t'(instruction[15:12]);
  assign alu_op  = alu_op_t'(instruction[3:0]);
  assign nn      = instruction[7:0];
  assign nnn     = instruction[11:0];
  assign pc2     = pc + 12'd2;
  assign pc4     = pc + 12'd4;
  assign add_sum = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    ctl          = '0;
    ctl.next_pc  = pc2;
    ctl.ret_addr = pc2;
    ctl.idx_val  = index;
    ctl.wr_reg   = instruction[11:8];
    unique case (cls)
      OP_SYS: begin
        priority if (instruction == INS_CLS) begin
          ctl.clr = 1'b1;
        end else if (instruction == INS_RET) begin
          if (stack_empty) begin
            ctl.fault = 1'b1;
          end else begin
            ctl.pop     = 1'b1;
            ctl.next_pc = stack_top;
          end
        end else begin
          ctl.unh = 1'b1;
        end
      end
      OP_JP: ctl.next_pc = nnn;
      OP_CALL: begin
        if (stack_full) begin
          ctl.fault = 1'b1;
        end else begin
          ctl.push    = 1'b1;
          ctl.next_pc = nnn;
        end
      end
      OP_SE_IMM:  if (vx == nn) ctl.next_pc = pc4;
      OP_SNE_IMM: if (vx != nn) ctl.next_pc = pc4;
      OP_SE_REG:  if (vx == vy) ctl.next_pc = pc4;
      OP_SNE_REG: if (vx != vy) ctl.next_pc = pc4;
      OP_LD_IMM: begin
        ctl.wr  = 1'b1;
        ctl.res = nn;
      end
      OP_ADD_IMM: begin
        ctl.wr  = 1'b1;
        ctl.res = vx + nn;
      end
      OP_ALU: begin
        ctl.wr = 1'b1;
        unique case (alu_op)
          ALU_MOV: ctl.res = vy;
          ALU_OR:  ctl.res = vx | vy;
          ALU_AND: ctl.res = vx & vy;
          ALU_XOR: ctl.res = vx ^ vy;
          ALU_ADD: begin
            ctl.res      = add_sum[7:0];
            ctl.set_flag = 1'b1;
            ctl.flag     = add_sum[8];
          end
          ALU_SUB: begin
            ctl.res      = vx - vy;
            ctl.set_flag = 1'b1;
            ctl.flag     = (vx >= vy);
          end
          ALU_SHR: begin
            ctl.res      = {1'b0, vx[7:1]};
            ctl.set_flag = 1'b1;
            ctl.flag     = vx[0];
          end
          ALU_SBN: begin
            ctl.res      = vy - vx;
            ctl.set_flag = 1'b1;
            ctl.flag     = (vy >= vx);
          end
          ALU_SHL: begin
            ctl.res      = {vx[6:0], 1'b0};
            ctl.set_flag = 1'b1;
            ctl.flag     = vx[7];
          end
          default: begin
            ctl.wr  = 1'b0;
            ctl.unh = 1'b1;
          end
        endcase
      end
      OP_LD_I: begin
        ctl.idx_wr  = 1'b1;
        ctl.idx_val = nnn;
      end
      OP_JP_V0: ctl.next_pc = nnn + {4'd0, v0};
      OP_RND: begin
        ctl.wr  = 1'b1;
        ctl.res = random_byte & nn;
      end
      OP_DRW: ctl.unh = 1'b1;
      OP_SKP: ctl.unh = 1'b1;
      OP_MISC: begin
        if (nn == NN_ADD_I) begin
          ctl.idx_wr  = 1'b1;
          ctl.idx_val = index + {4'd0, vx};
        end else begin
          ctl.unh = 1'b1;
        end
      end
    endcase
  end

endmodule

[sv/chip8_instruction_execute.sv]
// CHIP-8 instruction execute unit, top level
// Usage:
//   in_valid/in_ready/in_data carry one request: an instruction word and a
//   random byte. out_valid/out_ready/out_data carry one result per request:
//   next PC, index, register write, clear-screen, unhandled and fault flags.
//   cfg_we with cfg_wdata writes the program start address and loads the PC;
//   write it only while no request is in flight.
// Pipeline: an accepted request is held in the input register, then
//   executed into the output register.
// Throughput: one request per cycle while out_ready is high; the register
//   file, PC, index and return stack are all updated as the request executes.
// Reset: PC loads 512, index, data registers and stack level clear, both
//   pipeline stages empty. Return stack entries hold no reset value.
// Stall: when out_ready is low the result holds in the output register,
//   the next request waits in the input register, and in_ready drops once
//   both are full.
`timescale 1ns / 1ps
`include "chip8_instruction_execute_defines.svh"
module chip8_instruction_execute import chip8ie_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W = $clog2(STACK_DEPTH);

  logic             in_valid_r;
  in_t              in_data_r;
  logic             out_valid_r;
  out_t             out_data_r;
  out_t             out_data_nxt;
  logic [11:0]      pc_r;
  logic [11:0]      index_r;
  logic [LVL_W-1:0] level_r;
  logic [LVL_W-1:0] level_dec;
  logic [11:0]      stack_r [STACK_DEPTH];
  logic             exec_fire;
  logic             stack_full;
  logic             stack_empty;
  logic [7:0]       vx;
  logic [7:0]       vy;
  logic [7:0]       v0;
  exec_ctl_t        ctl;

  assign exec_fire   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready    = !in_valid_r || exec_fire;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;
  assign stack_full  = (level_r >= LVL_W'(STACK_DEPTH));
  assign stack_empty = (level_r == '0);
  assign level_dec   = level_r - LVL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_data_r <= in_data;
  end

  chip8ie_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (exec_fire && ctl.wr),
    .waddr   (ctl.wr_reg),
    .wdata   (ctl.res),
    .flag_we (exec_fire && ctl.set_flag),
    .flag    (ctl.flag),
    .raddr_x (in_data_r.instruction[11:8]),
    .raddr_y (in_data_r.instruction[7:4]),
    .rdata_x (vx),
    .rdata_y (vy),
    .rdata_0 (v0)
  );

  chip8ie_exec u_exec (
    .instruction (in_data_r.instruction),
    .random_byte (in_data_r.random_byte),
    .pc          (pc_r),
    .index       (index_r),
    .vx          (vx),
    .vy          (vy),
    .v0          (v0),
    .stack_top   (stack_r[level_dec[PTR_W-1:0]]),
    .stack_full  (stack_full),
    .stack_empty (stack_empty),
    .ctl         (ctl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= PROG_START_RST;
      index_r      <= '0;
      level_r      <= '0;
    end else if (cfg_we) begin
      pc_r         <= cfg_wdata;
    end else if (exec_fire) begin
      pc_r <= ctl.next_pc;
      if (ctl.idx_wr) index_r <= ctl.idx_val;
      if (ctl.push) begin
        level_r <= level_r + LVL_W'(1);
      end else if (ctl.pop) begin
        level_r <= level_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && ctl.push) stack_r[level_r[PTR_W-1:0]] <= ctl.ret_addr;
  end

  always_comb begin
    out_data_nxt              = '0;
    out_data_nxt.next_pc      = ctl.next_pc;
    out_data_nxt.index_value  = ctl.idx_wr ? ctl.idx_val : index_r;
    out_data_nxt.write_enable = ctl.wr;
    out_data_nxt.clear_screen = ctl.clr;
    out_data_nxt.not_handled  = ctl.unh;
    out_data_nxt.stack_fault  = ctl.fault;
    if (ctl.wr) begin
      out_data_nxt.write_reg   = ctl.wr_reg;
      out_data_nxt.write_value = (ctl.set_flag && ctl.wr_reg == FLAG_REG) ?
                                 {7'd0, ctl.flag} : ctl.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec_fire || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) out_data_r <= out_data_nxt;
  end

  `C8_ASSERT_IMP(a_level_bound, 1'b1, level_r <= LVL_W'(STACK_DEPTH), "stack level overflow")
  `C8_ASSERT_IMP(a_fault_no_move, ctl.fault, !ctl.push && !ctl.pop, "fault moved the stack")
  `C8_ASSERT_NXT(a_push_level, exec_fire && ctl.push && !cfg_we,
                 level_r == $past(level_r) + LVL_W'(1), "push did not raise level")
  `C8_ASSERT_NXT(a_exec_result, exec_fire, out_valid_r, "executed request produced no result")

endmodule

[sim/tb_chip8_instruction_execute.sv]
// Self-checking testbench for the CHIP-8 instruction execute unit
`timescale 1ns / 1ps
module tb_chip8_instruction_execute;
  import chip8ie_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int PHASE_ITEMS = 225;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [11:0] cfg_wdata = '0;

  in_t         instr_q[$];
  out_t        outcome_q[$];
  out_t        want;
  int          mismatch_count = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  logic [15:0] stall_cnt = '0;

  logic [7:0]  vreg[16];
  logic [11:0] idx_reg;
  logic [11:0] pc_reg;
  logic [11:0] ret_stack[STACK_DEPTH];
  int          stack_level;

  chip8_instruction_execute #(.STACK_DEPTH(STACK_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic out_t execute_ins(in_t req);
    logic [15:0] ins;
    logic [3:0]  x, y;
    logic [7:0]  nn, vx, vy, res, flag;
    logic [8:0]  sum;
    logic [11:0] nnn, nxt;
    logic        wr, set_flag;
    out_t        r;
    ins = req.instruction;
    x = ins[11:8];
    y = ins[7:4];
    nn = ins[7:0];
    nnn = ins[11:0];
    vx = vreg[x];
    vy = vreg[y];
    nxt = pc_reg + 12'd2;
    wr = 1'b0;
    set_flag = 1'b0;
    res = '0;
    flag = '0;
    r = '0;
    case (opclass_t'(ins[15:12]))
      OP_SYS: begin
        if (ins == INS_CLS) begin
          r.clear_screen = 1'b1;
        end else if (ins == INS_RET) begin
          if (stack_level == 0) begin
            r.stack_fault = 1'b1;
          end else begin
            stack_level--;
            nxt = ret_stack[stack_level];
          end
        end else begin
          r.not_handled = 1'b1;
        end
      end
      OP_JP: nxt = nnn;
      OP_CALL: begin
        if (stack_level >= STACK_DEPTH) begin
          r.stack_fault = 1'b1;
        end else begin
          ret_stack[stack_level] = nxt;
          stack_level++;
          nxt = nnn;
        end
      end
      OP_SE_IMM: if (vx == nn) nxt = pc_reg + 12'd4;
      OP_SNE_IMM: if (vx != nn) nxt = pc_reg + 12'd4;
      OP_SE_REG: if (vx == vy) nxt = pc_reg + 12'd4;
      OP_SNE_REG: if (vx != vy) nxt = pc_reg + 12'd4;
      OP_LD_IMM: begin
        wr = 1'b1;
        res = nn;
      end
      OP_ADD_IMM: begin
        wr = 1'b1;
        res = vx + nn;
      end
      OP_ALU: begin
        wr = 1'b1;
        case (alu_op_t'(ins[3:0]))
          ALU_MOV: res = vy;
          ALU_OR:  res = vx | vy;
          ALU_AND: res = vx & vy;
          ALU_XOR: res = vx ^ vy;
          ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            res = sum[7:0];
            flag = {7'd0, sum[8]};
            set_flag = 1'b1;
          end
          ALU_SUB: begin
            res = vx - vy;
            flag = (vx >= vy) ? 8'd1 : 8'd0;
            set_flag = 1'b1;
          end
          ALU_SHR: begin
            res = vx >> 1;
            flag = {7'd0, vx[0]};
            set_flag = 1'b1;
          end
          ALU_SBN: begin
            res = vy - vx;
            flag = (vy >= vx) ? 8'd1 : 8'd0;
            set_flag = 1'b1;
          end
          ALU_SHL: begin
            res = vx << 1;
            flag = {7'd0, vx[7]};
            set_flag = 1'b1;
          end
          default: begin
            wr = 1'b0;
            r.not_handled = 1'b1;
          end
        endcase
      end
      OP_LD_I: idx_reg = nnn;
      OP_JP_V0: nxt = nnn + {4'd0, vreg[0]};
      OP_RND: begin
        wr = 1'b1;
        res = req.random_byte & nn;
      end
      OP_MISC: begin
        if (nn == NN_ADD_I) idx_reg = idx_reg + {4'd0, vx};
        else r.not_handled = 1'b1;
      end
      default: r.not_handled = 1'b1;
    endcase
    if (wr) vreg[x] = res;
    if (set_flag) vreg[FLAG_REG] = flag;
    pc_reg = nxt;
    r.next_pc = pc_reg;
    r.index_value = idx_reg;
    r.write_enable = wr;
    r.write_reg = wr ? x : 4'd0;
    r.write_value = wr ? vreg[x] : 8'd0;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [15:0] exp_val, logic [15:0] act_val);
    mismatch_count++;
    $display("%0t: %s expected %h actual %h", $time, what, exp_val, act_val);
  endtask

  task automatic push_ins(logic [15:0] ins, int unsigned rnd);
    in_t req;
    req.instruction = ins;
    req.random_byte = 8'(rnd);
    instr_q.push_back(req);
  endtask

  task automatic add_segment();
    int          kind, d;
    logic [3:0]  x, y, n;
    logic [7:0]  a, b;
    logic [3:0]  alu_codes[9];
    alu_codes = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SBN,
                   ALU_SHL};
    kind = $urandom_range(0, 9);
    x = 4'($urandom);
    y = 4'($urandom);
    a = 8'($urandom);
    b = 8'($urandom);
    if ($urandom_range(0, 3) == 0) a = {8{a[0]}};
    if ($urandom_range(0, 3) == 0) b = {8{b[7]}};
    case (kind)
      0: repeat (6) push_ins(16'($urandom), $urandom);
      1, 2: begin
        d = $urandom_range(1, STACK_DEPTH + 2);
        repeat (d) push_ins({OP_CALL, 12'($urandom)}, $urandom);
        repeat ($urandom_range(0, 3)) push_ins({OP_ADD_IMM, x, a}, $urandom);
        repeat ($urandom_range(d - 1, d + 1)) push_ins(INS_RET, $urandom);
      end
      3, 4: begin
        push_ins({OP_LD_IMM, x, a}, $urandom);
        push_ins({OP_LD_IMM, y, b}, $urandom);
        if ($urandom_range(0, 9) == 0) n = 4'($urandom);
        else n = alu_codes[$urandom_range(0, 8)];
        push_ins({OP_ALU, x, y, n}, $urandom);
        if ($urandom_range(0, 1) == 0)
          push_ins({OP_ALU, FLAG_REG, x, alu_codes[$urandom_range(0, 8)]}, $urandom);
      end
      5: begin
        push_ins({OP_LD_IMM, x, a}, $urandom);
        if ($urandom_range(0, 1) == 0) b = a;
        push_ins({($urandom_range(0, 1) == 0) ? OP_SE_IMM : OP_SNE_IMM, x, b}, $urandom);
        push_ins({OP_LD_IMM, y, ($urandom_range(0, 1) == 0) ? a : b}, $urandom);
        push_ins({($urandom_range(0, 1) == 0) ? OP_SE_REG : OP_SNE_REG, x, y,
                  4'($urandom)}, $urandom);
      end
      6: begin
        push_ins({OP_LD_I, 12'($urandom)}, $urandom);
        push_ins({OP_LD_IMM, x, a}, $urandom);
        push_ins({OP_MISC, x, NN_ADD_I}, $urandom);
        push_ins({OP_JP_V0, 12'($urandom)}, $urandom);
        push_ins({OP_JP, 12'($urandom)}, $urandom);
      end
      7: push_ins({OP_RND, x, a}, $urandom);
      8: begin
        case ($urandom_range(0, 4))
          0: push_ins({OP_SYS, 12'($urandom)}, $urandom);
          1: push_ins({OP_DRW, 12'($urandom)}, $urandom);
          2: push_ins({OP_SKP, 12'($urandom)}, $urandom);
          3: push_ins({OP_MISC, x, (a == NN_ADD_I) ? ~a : a}, $urandom);
          default: push_ins({OP_ALU, x, y, 4'($urandom_range(8, 13))}, $urandom);
        endcase
      end
      default: begin
        push_ins({OP_CALL, 12'($urandom)}, $urandom);
        push_ins(INS_CLS, $urandom);
        push_ins(INS_RET, $urandom);
      end
    endcase
  endtask

  task automatic wait_drained();
    while (instr_q.size() != 0 || in_valid || outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_program_start(logic [11:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    pc_reg = value;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (in_valid && in_ready) outcome_q.push_back(execute_ins(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (instr_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= instr_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_cnt <= '0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          flag_mismatch("unexpected result, expected none", '0, out_data[15:0]);
        end else begin
          want = outcome_q.pop_front();
          if (out_data.next_pc !== want.next_pc)
            flag_mismatch("next_pc", 16'(want.next_pc), 16'(out_data.next_pc));
          if (out_data.index_value !== want.index_value)
            flag_mismatch("index_value", 16'(want.index_value), 16'(out_data.index_value));
          if (out_data.write_enable !== want.write_enable)
            flag_mismatch("write_enable", 16'(want.write_enable),
                          16'(out_data.write_enable));
          if (out_data.write_reg !== want.write_reg)
            flag_mismatch("write_reg", 16'(want.write_reg), 16'(out_data.write_reg));
          if (out_data.write_value !== want.write_value)
            flag_mismatch("write_value", 16'(want.write_value), 16'(out_data.write_value));
          if (out_data.clear_screen !== want.clear_screen)
            flag_mismatch("clear_screen", 16'(want.clear_screen),
                          16'(out_data.clear_screen));
          if (out_data.not_handled !== want.not_handled)
            flag_mismatch("not_handled", 16'(want.not_handled), 16'(out_data.not_handled));
          if (out_data.stack_fault !== want.stack_fault)
            flag_mismatch("stack_fault", 16'(want.stack_fault), 16'(out_data.stack_fault));
        end
      end
      stall_cnt <= stall_cnt + 16'd1;
      case (stall_cnt[8:7])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready <= (stall_cnt[2:0] == 3'd0);
        default: out_ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  initial begin
    logic [11:0] start_addr[4];
    foreach (vreg[i]) vreg[i] = '0;
    foreach (ret_stack[i]) ret_stack[i] = '0;
    idx_reg = '0;
    pc_reg = PROG_START_RST;
    stack_level = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    push_ins(INS_CLS, $urandom);
    push_ins(INS_RET, $urandom);
    push_ins({OP_SYS, 12'hABC}, $urandom);
    push_ins({OP_LD_IMM, 4'hA, 8'hFF}, $urandom);
    push_ins({OP_LD_IMM, 4'hB, 8'h01}, $urandom);
    push_ins({OP_ALU, 4'hA, 4'hB, ALU_ADD}, $urandom);
    push_ins({OP_ALU, 4'hA, 4'hB, ALU_SUB}, $urandom);
    push_ins({OP_ALU, 4'hA, 4'hB, ALU_SHR}, $urandom);
    push_ins({OP_ALU, 4'hA, 4'hB, ALU_SHL}, $urandom);
    push_ins({OP_ALU, 4'hA, 4'hB, ALU_SBN}, $urandom);
    push_ins({OP_ALU, FLAG_REG, 4'hA, ALU_ADD}, $urandom);
    push_ins({OP_ALU, 4'hA, 4'hB, ALU_MOV}, $urandom);
    push_ins({OP_ALU, 4'hA, 4'hB, ALU_OR}, $urandom);
    push_ins({OP_ALU, 4'hA, 4'hB, ALU_AND}, $urandom);
    push_ins({OP_ALU, 4'hA, 4'hB, ALU_XOR}, $urandom);
    push_ins({OP_ALU, 4'hA, 4'hB, 4'h9}, $urandom);
    push_ins({OP_ADD_IMM, 4'hA, 8'hFF}, $urandom);
    push_ins({OP_SE_IMM, 4'hA, 8'h00}, $urandom);
    push_ins({OP_SNE_IMM, 4'hA, 8'h00}, $urandom);
    push_ins({OP_SE_REG, 4'hA, 4'hB, 4'h0}, $urandom);
    push_ins({OP_SNE_REG, 4'hA, 4'hB, 4'hF}, $urandom);
    push_ins({OP_LD_I, 12'hFFF}, $urandom);
    push_ins({OP_MISC, 4'hA, NN_ADD_I}, $urandom);
    push_ins({OP_MISC, 4'h0, 8'h0A}, $urandom);
    push_ins({OP_LD_IMM, 4'h0, 8'hFF}, $urandom);
    push_ins({OP_JP_V0, 12'hFFF}, $urandom);
    push_ins({OP_RND, 4'hA, 8'hFF}, 'hFF);
    push_ins({OP_RND, 4'h5, 8'hA5}, 'h5A);
    push_ins({OP_CALL, 12'hFFE}, $urandom);
    push_ins(INS_RET, $urandom);
    push_ins({OP_JP, 12'h000}, $urandom);
    push_ins({OP_DRW, 12'h123}, $urandom);
    push_ins({OP_SKP, 12'h1A1}, $urandom);
    wait_drained();

    start_addr = '{12'h000, 12'hFFF, 12'($urandom), 12'($urandom)};
    foreach (start_addr[p]) begin
      write_program_start(start_addr[p]);
      while (instr_q.size() < PHASE_ITEMS) add_segment();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[chip8_instruction_execute.f]
+incdir+sv
sv/chip8ie_pkg.sv
sv/chip8ie_regfile.sv
sv/chip8ie_exec.sv
sv/chip8_instruction_execute.sv
sim/tb_chip8_instruction_execute.sv
